>>> hw/rtl/lcs_pkg.sv
// shared constants, command, status and state types for the longest common substring core
package lcs_pkg;

    localparam int LCS_MAX_LEN = 64;
    localparam int LCS_SYM_W   = 8;
    localparam int LCS_LEN_W   = 7;

    typedef struct packed {
        logic load;
        logic run_init;
        logic col_init;
        logic calc;
        logic row_next;
        logic out_sel;
        logic out_load;
        logic out_empty;
    } lcs_cmd_t;

    typedef struct packed {
        logic first_empty;
        logic col_last;
        logic row_last;
        logic best_zero;
        logic out_last;
        logic out_free;
    } lcs_sts_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_START     = 9'b000000010,
        ST_ROW_ADDR  = 9'b000000100,
        ST_ROW_CELL  = 9'b000001000,
        ST_DRAIN     = 9'b000010000,
        ST_OUT_START = 9'b000100000,
        ST_OUT_ADDR  = 9'b001000000,
        ST_OUT_LOAD  = 9'b010000000,
        ST_EMPTY     = 9'b100000000
    } lcs_state_t;

endpackage

>>> hw/rtl/lcs_ctrl.sv
// sequencer for loading, the row by row match table and the result stream
module lcs_ctrl import lcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     symbol_valid,
    input  logic     mode,
    input  logic     last_in,
    input  lcs_sts_t sts,
    output lcs_cmd_t cmd,
    output logic     symbol_stall
);

    lcs_state_t state_reg;
    lcs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        symbol_stall = 1'b1;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                symbol_stall = 1'b0;
                cmd.load     = symbol_valid;
                if (symbol_valid && mode && last_in)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.run_init = 1'b1;
                state_next   = sts.first_empty ? ST_EMPTY : ST_ROW_ADDR;
            end
            ST_ROW_ADDR:
            begin
                cmd.col_init = 1'b1;
                state_next   = ST_ROW_CELL;
            end
            ST_ROW_CELL:
            begin
                cmd.calc = 1'b1;
                if (sts.col_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.row_next = 1'b1;
                state_next   = sts.row_last ? ST_OUT_START : ST_ROW_ADDR;
            end
            ST_OUT_START:
            begin
                state_next = sts.best_zero ? ST_EMPTY : ST_OUT_ADDR;
            end
            ST_OUT_ADDR:
            begin
                cmd.out_sel = 1'b1;
                state_next  = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                cmd.out_sel = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.out_last ? ST_IDLE : ST_OUT_ADDR;
                end
            end
            ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/lcs_dp.sv
// string stores, match row memory, cell pipeline, best tracking and output register
module lcs_dp import lcs_pkg::*;
#(
    parameter int MAX_LEN = LCS_MAX_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcs_cmd_t             cmd,
    output lcs_sts_t             sts,
    input  logic                 mode,
    input  logic [LCS_SYM_W-1:0] symbol_in,
    input  logic                 last_in,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [LCS_SYM_W-1:0] match_char,
    output logic [LCS_LEN_W-1:0] match_length,
    output logic                 final_char,
    output logic                 is_empty
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic [LCS_SYM_W-1:0] first_mem  [MAX_LEN];
    logic [LCS_SYM_W-1:0] second_mem [MAX_LEN];
    logic [CNT_W-1:0]     row_mem    [MAX_LEN];

    logic [CNT_W-1:0]     first_count_reg;
    logic [CNT_W-1:0]     second_count_reg;
    logic                 first_closed_reg;
    logic                 second_closed_reg;

    logic [IDX_W-1:0]     row_reg;
    logic [IDX_W-1:0]     col_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [CNT_W-1:0]     best_len_reg;
    logic [IDX_W-1:0]     best_end_reg;

    logic                 cell_v_reg;
    logic [IDX_W-1:0]     cell_col_reg;
    logic                 cell_zero_reg;

    logic [LCS_SYM_W-1:0] first_q;
    logic [LCS_SYM_W-1:0] second_q;
    logic [CNT_W-1:0]     row_q;

    logic                 result_valid_reg;
    logic [LCS_SYM_W-1:0] match_char_reg;
    logic [LCS_LEN_W-1:0] match_length_reg;
    logic                 final_char_reg;
    logic                 is_empty_reg;

    logic                 load_closed;
    logic [CNT_W-1:0]     load_cnt;
    logic [CNT_W-1:0]     load_base;
    logic                 load_room;
    logic [IDX_W-1:0]     load_addr;
    logic [CNT_W-1:0]     load_count_next;
    logic [CNT_W-1:0]     cell_val;
    logic [CNT_W-1:0]     out_sum;
    logic [IDX_W-1:0]     first_raddr;

    // loading
    always_comb
    begin
        load_closed     = mode ? second_closed_reg : first_closed_reg;
        load_cnt        = mode ? second_count_reg : first_count_reg;
        load_base       = load_closed ? '0 : load_cnt;
        load_room       = (load_base < MAX_CNT);
        load_addr       = load_base[IDX_W-1:0];
        load_count_next = load_room ? load_base + ONE_CNT : load_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg   <= '0;
            second_count_reg  <= '0;
            first_closed_reg  <= 1'b1;
            second_closed_reg <= 1'b1;
        end
        else if (cmd.load)
        begin
            if (mode)
            begin
                second_count_reg  <= load_count_next;
                second_closed_reg <= last_in;
            end
            else
            begin
                first_count_reg  <= load_count_next;
                first_closed_reg <= last_in;
            end
        end
    end

    // first string read address: current row while matching, substring position on output
    always_comb
    begin
        out_sum     = CNT_W'(best_end_reg) + ONE_CNT - best_len_reg + CNT_W'(k_reg);
        first_raddr = cmd.out_sel ? out_sum[IDX_W-1:0] : row_reg;
    end

    // cell value, second pipeline stage
    always_comb
    begin
        if (first_q == second_q)
        begin
            cell_val = cell_zero_reg ? ONE_CNT : row_q + ONE_CNT;
        end
        else
        begin
            cell_val = '0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_room && !mode)
        begin
            first_mem[load_addr] <= symbol_in;
        end
        first_q <= first_mem[first_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_room && mode)
        begin
            second_mem[load_addr] <= symbol_in;
        end
        second_q <= second_mem[col_reg];
    end

    // entry c holds the count for column c+1; columns run downwards so the old row stays readable
    always_ff @(posedge clk)
    begin
        if (cell_v_reg)
        begin
            row_mem[cell_col_reg] <= cell_val;
        end
        row_q <= row_mem[col_reg - 1'b1];
    end

    // counters and cell stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            row_reg <= '0;
        end
        else if (cmd.row_next)
        begin
            row_reg <= row_reg + 1'b1;
        end

        if (cmd.col_init)
        begin
            col_reg <= IDX_W'(second_count_reg - ONE_CNT);
        end
        else if (cmd.calc)
        begin
            col_reg <= col_reg - 1'b1;
        end

        if (cmd.run_init)
        begin
            k_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            k_reg <= k_reg + 1'b1;
        end

        cell_col_reg  <= col_reg;
        cell_zero_reg <= (col_reg == '0) || (row_reg == '0);
    end

    // cell stage valid and best match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_v_reg   <= 1'b0;
            best_len_reg <= '0;
            best_end_reg <= '0;
        end
        else
        begin
            cell_v_reg <= cmd.calc;
            if (cmd.run_init)
            begin
                best_len_reg <= '0;
                best_end_reg <= '0;
            end
            else if (cell_v_reg && (cell_val > best_len_reg))
            begin
                best_len_reg <= cell_val;
                best_end_reg <= row_reg;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load || cmd.out_empty)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            match_char_reg   <= first_q;
            match_length_reg <= LCS_LEN_W'(best_len_reg);
            final_char_reg   <= sts.out_last;
            is_empty_reg     <= 1'b0;
        end
        else if (cmd.out_empty)
        begin
            match_char_reg   <= '0;
            match_length_reg <= '0;
            final_char_reg   <= 1'b1;
            is_empty_reg     <= 1'b1;
        end
    end

    always_comb
    begin
        sts.first_empty = (first_count_reg == '0);
        sts.col_last    = (col_reg == '0);
        sts.row_last    = ((CNT_W'(row_reg) + ONE_CNT) == first_count_reg);
        sts.best_zero   = (best_len_reg == '0);
        sts.out_last    = ((CNT_W'(k_reg) + ONE_CNT) == best_len_reg);
        sts.out_free    = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign match_char   = match_char_reg;
    assign match_length = match_length_reg;
    assign final_char   = final_char_reg;
    assign is_empty     = is_empty_reg;

endmodule

>>> hw/rtl/longest_common_substring_core.sv
// top level of the longest common substring core
//
// symbol channel: symbol_valid / symbol_stall with mode, symbol_in, last_in. mode 0 words
// load the first string, mode 1 words the second; last_in closes a string, the next word for
// a closed string starts it afresh. words past MAX_LEN symbols are dropped.
// words are loaded one per cycle while symbol_stall is low. a mode 1 word with last_in starts the match run and
// symbol_stall stays high until the last result word has entered the output register.
// the match table is swept by one shared cell unit, one cell per cycle within a row, over a single row
// memory, with an address state before and a drain state after each row.
// result channel: result_valid / result_stall with match_char, match_length, final_char and
// is_empty. the substring leaves one word at a time, each read from the first string store, the
// last word carrying final_char. with no common substring a single word with is_empty and
// final_char is sent. a stalled result word holds in the output register; the next word waits.
// reset empties both strings and the output register; no clearing pass is needed
module longest_common_substring_core import lcs_pkg::*;
#(
    parameter int MAX_LEN = LCS_MAX_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 symbol_valid,
    output logic                 symbol_stall,
    input  logic                 mode,
    input  logic [LCS_SYM_W-1:0] symbol_in,
    input  logic                 last_in,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [LCS_SYM_W-1:0] match_char,
    output logic [LCS_LEN_W-1:0] match_length,
    output logic                 final_char,
    output logic                 is_empty
);

    lcs_cmd_t cmd;
    lcs_sts_t sts;

    lcs_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol_valid (symbol_valid),
        .mode         (mode),
        .last_in      (last_in),
        .sts          (sts),
        .cmd          (cmd),
        .symbol_stall (symbol_stall)
    );

    lcs_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .symbol_in    (symbol_in),
        .last_in      (last_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_char   (match_char),
        .match_length (match_length),
        .final_char   (final_char),
        .is_empty     (is_empty)
    );

endmodule
